[rtl/md5_pkg.sv]
// MD5 package: chaining-word type, initial chain, round constant ROM,
// shift table and message index schedule. No dependencies.
`default_nettype none
package md5_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_work;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // sine-derived additive constant for each round
    function automatic logic [31:0] md5_k(input logic [5:0] rnd);
        logic [31:0] k;
        case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // rotate amount per group and round within the group of four
    function automatic logic [4:0] md5_shift(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
            4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  4'hF: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index for a round
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
        logic [3:0] q;
        logic [3:0] g;
        q = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = q;
            2'd1:    g = 4'((q << 2) + q + 4'd1);
            2'd2:    g = 4'((q << 1) + q + 4'd5);
            default: g = 4'((q << 3) - q);
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[rtl/md5_rnd.sv]
// MD5 round unit: one step of the compression function per use.
// Depends on md5_pkg.
`default_nettype none
module md5_rnd
    import md5_pkg::*;
(
    input  wire t_work       i_work,
    input  wire logic [5:0]  i_round,
    input  wire logic [31:0] i_msg,
    output t_work            o_work
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;

    // boolean function per group
    always_comb begin
        case (i_round[5:4])
            2'd0:    f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            2'd1:    f = (i_work.d & i_work.b) | (~i_work.d & i_work.c);
            2'd2:    f = i_work.b ^ i_work.c ^ i_work.d;
            default: f = i_work.c ^ (i_work.b | ~i_work.d);
        endcase
    end

    assign sum = i_work.a + f + md5_k(i_round) + i_msg;
    assign rot = {sum, sum} << md5_shift(i_round);

    // rotate the working words
    assign o_work.a = i_work.d;
    assign o_work.d = i_work.c;
    assign o_work.c = i_work.b;
    assign o_work.b = i_work.b + rot[63:32];

endmodule
`default_nettype wire

[rtl/md5_digest_stream.sv]
// MD5 over a word stream: one byte per cycle into the block buffer, paused while a
// full block compresses; one round per cycle, then a fold step per 64-byte block.
// A new word is taken only in idle, so the block is through with one word before the
// next. Input stall is high while busy.
// Last word: pad bytes, the length word, one or two compressions, then four digest
// transactions. Sync active-low reset loads the chain, clears the count.
`default_nettype none
module md5_digest_stream
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic             o_digest_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_BYTE, S_PAD, S_LEN, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state       r_state;
    t_state       r_ret;
    logic [31:0]  r_data;
    logic [2:0]   r_n;
    logic [2:0]   r_bi;
    logic         r_last;
    logic [28:0]  r_count;
    logic [5:0]   r_ppos;
    logic         r_mark;
    logic [5:0]   r_round;
    logic [1:0]   r_oi;
    t_work        r_chain;
    t_work        r_work;
    logic [31:0]  r_buf [16];

    logic [5:0]   pos;
    logic [7:0]   cur_byte;
    t_work        rnd_out;
    logic [31:0]  msg;

    assign pos      = r_count[5:0];
    assign cur_byte = r_data[{r_bi[1:0], 3'b000} +: 8];
    assign msg      = r_buf[md5_msg_idx(r_round)];

    md5_rnd u_rnd (
        .i_work  (r_work),
        .i_round (r_round),
        .i_msg   (msg),
        .o_work  (rnd_out)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    always_comb begin
        case (r_oi)
            2'd0:    o_digest_word = r_chain.a;
            2'd1:    o_digest_word = r_chain.b;
            2'd2:    o_digest_word = r_chain.c;
            default: o_digest_word = r_chain.d;
        endcase
    end
    assign o_digest_last = (r_oi == 2'd3);

    // block buffer: byte inserts, pad bytes and the length word
    always_ff @(posedge i_clk) begin
        if (r_state == S_BYTE && r_bi != r_n) begin
            r_buf[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= cur_byte;
        end else if (r_state == S_PAD) begin
            r_buf[r_ppos[5:2]][{r_ppos[1:0], 3'b000} +: 8] <= r_mark ? PAD_MARK : 8'h00;
        end else if (r_state == S_LEN) begin
            r_buf[14] <= {r_count, 3'b000};
            r_buf[15] <= 32'h0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_n     <= 3'd0;
            r_bi    <= 3'd0;
            r_last  <= 1'b0;
            r_count <= 29'd0;
            r_ppos  <= 6'd0;
            r_mark  <= 1'b0;
            r_round <= 6'd0;
            r_oi    <= 2'd0;
            r_chain <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
            r_work  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data  <= i_data_word;
                        r_n     <= (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
                        r_last  <= i_last_item;
                        r_bi    <= 3'd0;
                        r_state <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (r_bi != r_n) begin
                        r_bi    <= r_bi + 3'd1;
                        r_count <= r_count + 29'd1;
                        if (pos == 6'd63) begin
                            r_work  <= r_chain;
                            r_round <= 6'd0;
                            r_ret   <= S_BYTE;
                            r_state <= S_ROUND;
                        end
                    end else if (r_last) begin
                        r_ppos  <= pos;
                        r_mark  <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    r_mark <= 1'b0;
                    r_ppos <= r_ppos + 6'd1;
                    if (r_ppos == 6'd63) begin
                        r_work  <= r_chain;
                        r_round <= 6'd0;
                        r_ret   <= S_PAD;
                        r_state <= S_ROUND;
                    end else if (r_ppos == 6'd55) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_work  <= r_chain;
                    r_round <= 6'd0;
                    r_ret   <= S_OUT;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_work  <= rnd_out;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_chain.a <= r_chain.a + r_work.a;
                    r_chain.b <= r_chain.b + r_work.b;
                    r_chain.c <= r_chain.c + r_work.c;
                    r_chain.d <= r_chain.d + r_work.d;
                    r_oi      <= 2'd0;
                    r_state   <= r_ret;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oi <= r_oi + 2'd1;
                        if (r_oi == 2'd3) begin
                            r_chain <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
                            r_count <= 29'd0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/md5_chk.sv]
// Port-level checker for md5_digest_stream, bound to the top level.
// No package dependencies.
`default_nettype none
module md5_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic        o_digest_last
);

    // a digest transaction only while the input side is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("digest while input open");

    // an accepted input transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after accept");

    // a stalled digest word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)
                                  && $stable(o_digest_last)))
        else $error("stalled digest changed");

    // after the final digest word the block is ready again
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_last) |=> (!o_valid && !o_stall))
        else $error("not idle after digest");

endmodule

bind md5_digest_stream md5_chk u_md5_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_word (o_digest_word),
    .o_digest_last (o_digest_last)
);
`default_nettype wire
